// ===== hdl/a256cm_pkg.sv =====
// shared types, constants and aes helper functions for the counter mix block
package a256cm_pkg;

    localparam int unsigned ROUNDS = 14;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd1: r = 8'h01;
            3'd2: r = 8'h02;
            3'd3: r = 8'h04;
            3'd4: r = 8'h08;
            3'd5: r = 8'h10;
            3'd6: r = 8'h20;
            3'd7: r = 8'h40;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // word bytes: byte j in bits 8j+7:8j
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [31:0] rot_word(input logic [31:0] w);
        return {w[7:0], w[31:8]};
    endfunction

    // one aes round on a little-endian byte block, mix skipped on the last
    function automatic t_block aes_round(input t_block s, input t_block rk,
                                         input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[4*c+i] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[8*i +: 8] = t[i] ^ rk[8*i +: 8];
        end
        return o;
    endfunction

endpackage

// ===== hdl/aes256_counter_mix.sv =====
// top level: counter expansion, aes-256 pipeline and output register
//
// channel | dir | fields
// s_axis  | in  | tdata: key_word_0..3, counter_low, counter_high; tuser: final_macro
// m_axis  | out | tdata: cipher_low, cipher_high; tuser: block_index, buffer_end; tlast
//
// each macro item yields COUNTER_BLOCKS counter blocks from the issue counter that
// feeds the 15-stage round pipeline; the next item is taken with the last issue
// results leave the round pipeline through the output register
// synchronous active-low reset clears all valid bits and the issue counter
// an output stall freezes the whole pipeline; the input waits for the issuer
module aes256_counter_mix #(
    parameter int unsigned COUNTER_BLOCKS = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,  // key_word_0..3, counter_low, counter_high
    input  logic         s_axis_tuser,  // final_macro
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // cipher_low, cipher_high
    output logic [2:0]   m_axis_tuser,  // block_index[1:0], buffer_end
    output logic         m_axis_tlast   // last_of_macro
);
    localparam int unsigned CW = (COUNTER_BLOCKS > 1) ? $clog2(COUNTER_BLOCKS) : 1;
    localparam int unsigned TAG_W = CW + 2;

    logic          r_busy;
    logic [CW-1:0] r_idx;
    logic [383:0]  r_item;
    logic          r_fin;
    logic          en, issue, last_issue;
    logic          core_vld;
    a256cm_pkg::t_block core_blk;
    logic [TAG_W-1:0]   core_tag;
    logic [127:0]  ctr;
    logic          r_ovld;
    logic [127:0]  r_odata;
    logic [2:0]    r_ouser;
    logic          r_olast;

    assign en            = !r_ovld || m_axis_tready;
    assign issue         = r_busy && en;
    assign last_issue    = r_idx == CW'(COUNTER_BLOCKS - 1);
    assign s_axis_tready = !r_busy || (issue && last_issue);
    assign ctr           = r_item[383:256] + 128'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (issue) r_idx <= last_issue ? '0 : r_idx + CW'(1);
            if (s_axis_tvalid && s_axis_tready) r_busy <= 1'b1;
            else if (issue && last_issue) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= s_axis_tdata;
            r_fin  <= s_axis_tuser;
        end
    end

    a256cm_core #(.TAG_W(TAG_W)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (issue),
        .i_key   (r_item[255:0]),
        .i_block (ctr),
        .i_tag   ({last_issue, last_issue & r_fin, r_idx}),
        .o_valid (core_vld),
        .o_block (core_blk),
        .o_tag   (core_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= core_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= core_blk;
            r_ouser <= {core_tag[CW], 2'(core_tag[CW-1:0])};
            r_olast <= core_tag[CW+1];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(COUNTER_BLOCKS - 1)) else $error("issue index out of range");
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == '0) else $error("index not zero while idle");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_axis_tready |=> r_ovld && $stable(r_odata))
        else $error("stalled result changed");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_ouser[2] |-> r_olast) else $error("buffer end off last");
endmodule

// ===== hdl/a256cm_core.sv =====
// pipelined aes-256 core: initial add at stage 0, then one round per stage, with a key schedule step from stage 2 on
module a256cm_core #(
    parameter int unsigned TAG_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [255:0]         i_key,
    input  a256cm_pkg::t_block   i_block,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output a256cm_pkg::t_block   o_block,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int unsigned NS = a256cm_pkg::ROUNDS + 1;

    logic                 r_vld [NS];
    a256cm_pkg::t_block   r_st  [NS];
    logic [255:0]         r_key [NS];
    logic [TAG_W-1:0]     r_tag [NS];

    // stage 0: initial add; key window holds round keys s-1,s at stage s (0,1 at stage 0)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= i_block ^ i_key[127:0];
            r_key[0] <= i_key;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_rnd
        logic [255:0]       n_key;
        a256cm_pkg::t_block n_st;
        logic [31:0]        w0, w1, w2, w3;
        always_comb begin
            n_key = r_key[s-1];
            if (s % 2 == 0) begin
                // next four schedule words from the window
                w0 = r_key[s-1][31:0] ^ a256cm_pkg::rot_word(
                         a256cm_pkg::sub_word(r_key[s-1][255:224]))
                     ^ {24'd0, a256cm_pkg::rcon(3'(s / 2))};
                w1 = r_key[s-1][63:32] ^ w0;
                w2 = r_key[s-1][95:64] ^ w1;
                w3 = r_key[s-1][127:96] ^ w2;
                n_key = {w3, w2, w1, w0, r_key[s-1][255:128]};
            end else if (s > 2) begin
                w0 = r_key[s-1][31:0] ^ a256cm_pkg::sub_word(r_key[s-1][255:224]);
                w1 = r_key[s-1][63:32] ^ w0;
                w2 = r_key[s-1][95:64] ^ w1;
                w3 = r_key[s-1][127:96] ^ w2;
                n_key = {w3, w2, w1, w0, r_key[s-1][255:128]};
            end else begin
                w0 = '0; w1 = '0; w2 = '0; w3 = '0;
            end
            // stage 1 uses upper half before shift, later stages the fresh words
            n_st = a256cm_pkg::aes_round(r_st[s-1],
                       (s % 2 == 1) ? (s == 1 ? r_key[s-1][255:128]
                                              : n_key[255:128])
                                    : n_key[255:128],
                       s == NS - 1);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s]  <= n_st;
                r_key[s] <= n_key;
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_block = r_st[NS-1];
    assign o_tag   = r_tag[NS-1];
endmodule
